// File: src/bubble_sort_engine_top_assert.svh
// ----------------------------------------------------------------------------
// bubble_sort_engine_top_assert.svh
// Assertion macros used by the sort engine sequencer, bse_ctrl. The enclosing module
// must provide clk and rst_n (synchronous, active low).
// ----------------------------------------------------------------------------
`ifndef BUBBLE_SORT_ENGINE_TOP_ASSERT_SVH
`define BUBBLE_SORT_ENGINE_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BSE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/bse_pkg.sv
// ----------------------------------------------------------------------------
// bse_pkg
// Shared types and constants for the bubble sort engine.
// ----------------------------------------------------------------------------
package bse_pkg;

  localparam int DATA_W    = 32;
  localparam int DEPTH_DEF = 64;

  // Input beat: one element, plus the end-of-set mark
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last_item;
  } in_beat_t;

  // Result beat: one sorted element
  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_result;
    logic                     overflowed;
  } out_beat_t;

  // Result handed from the sequencer to the output register
  typedef struct packed {
    logic      valid;
    out_beat_t beat;
  } emit_t;

endpackage

// File: src/bubble_sort_engine_top.sv
// Loading takes one beat per cycle; after the last beat the sort runs P passes
// (P <= n, n = stored elements) through PRIME, CARRY, STEP and TAIL, then results
// leave at one per cycle unless out_stall holds them, after an EREAD buffer read and the output register.
// One set is handled at a time: input stalls from the last beat until the final result
// is emitted, since the single comparator and buffer serve loading, passes and output.
// Reset: synchronous active-low rst_n clears count, overflow, state and output valid; buffer keeps data.
// ----------------------------------------------------------------------------
// bubble_sort_engine_top
// Collects signed elements until a last mark, sorts them ascending with an
// early-exit bubble sort, and streams them out through an output register.
// ----------------------------------------------------------------------------
module bubble_sort_engine_top #(
  parameter int DEPTH = bse_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bse_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  input  logic               out_stall,
  output bse_pkg::out_beat_t out_beat
);
  import bse_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic signed [DATA_W-1:0] mem_wdata;
  logic [AW-1:0]            mem_raddr;
  logic signed [DATA_W-1:0] mem_rdata;
  emit_t                    emit;
  logic                     out_free;
  logic                     out_valid_r;
  out_beat_t                out_beat_r;

  bse_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bse_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_free  (out_free),
    .emit      (emit),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Output register is free when empty or being taken this cycle
  assign out_free = !out_valid_r || !out_stall;

  // Load a new beat, or drop the current one once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_beat_r <= emit.beat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

// File: src/bse_store.sv
// ----------------------------------------------------------------------------
// bse_store
// Element buffer: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bse_store #(
  parameter int DEPTH = bse_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [AW-1:0]                   waddr,
  input  logic signed [bse_pkg::DATA_W-1:0] wdata,
  input  logic [AW-1:0]                   raddr,
  output logic signed [bse_pkg::DATA_W-1:0] rdata
);
  import bse_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: src/bse_ctrl.sv
// ----------------------------------------------------------------------------
// bse_ctrl
// Sequencer: loads elements, runs bubble passes with a single carried element
// and one comparator, then streams the sorted buffer out.
// ----------------------------------------------------------------------------
`include "bubble_sort_engine_top_assert.svh"

module bse_ctrl #(
  parameter int DEPTH = bse_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  bse_pkg::in_beat_t                 in_beat,
  input  logic                              out_free,
  output bse_pkg::emit_t                    emit,
  output logic                              mem_we,
  output logic [AW-1:0]                     mem_waddr,
  output logic signed [bse_pkg::DATA_W-1:0] mem_wdata,
  output logic [AW-1:0]                     mem_raddr,
  input  logic signed [bse_pkg::DATA_W-1:0] mem_rdata
);
  import bse_pkg::*;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_PRIME = 3'd1;
  localparam logic [2:0] S_CARRY = 3'd2;
  localparam logic [2:0] S_STEP  = 3'd3;
  localparam logic [2:0] S_TAIL  = 3'd4;
  localparam logic [2:0] S_EREAD = 3'd5;
  localparam logic [2:0] S_EOUT  = 3'd6;

  logic [2:0]               state_r, state_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic                     ovf_r, ovf_nxt;
  logic [AW-1:0]            j_r, j_nxt;
  logic [AW-1:0]            k_r, k_nxt;
  logic                     swp_r, swp_nxt;
  logic signed [DATA_W-1:0] carry_r, carry_nxt;

  logic [CW-1:0] cm1;
  logic          room;
  logic [CW-1:0] n_after;
  logic          emit_last;

  assign cm1       = cnt_r - CW'(1);
  assign room      = (cnt_r < CW'(DEPTH));
  assign n_after   = room ? (cnt_r + CW'(1)) : cnt_r;
  assign emit_last = (CW'(k_r) == cm1);

  // Next-state and datapath control
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    swp_nxt   = swp_r;
    carry_nxt = carry_r;
    mem_we    = 1'b0;
    mem_waddr = cnt_r[AW-1:0];
    mem_wdata = in_beat.value;
    mem_raddr = j_r;
    in_stall  = 1'b1;
    emit      = '0;
    case (state_r)
      S_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          // store the element, or drop it when the buffer is full
          if (room) begin
            mem_we  = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_beat.last_item) begin
            k_nxt = '0;
            if (n_after < CW'(2)) begin
              state_nxt = S_EREAD;
            end else begin
              state_nxt = S_PRIME;
            end
          end
        end
      end
      S_PRIME: begin
        // fetch the head of the buffer to start a pass
        mem_raddr = '0;
        j_nxt     = AW'(1);
        swp_nxt   = 1'b0;
        state_nxt = S_CARRY;
      end
      S_CARRY: begin
        carry_nxt = mem_rdata;
        mem_raddr = j_r;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        // compare the carried element with entry j, write back the smaller one
        mem_we    = 1'b1;
        mem_waddr = j_r - AW'(1);
        if (carry_r > mem_rdata) begin
          mem_wdata = mem_rdata;
          swp_nxt   = 1'b1;
        end else begin
          mem_wdata = carry_r;
          carry_nxt = mem_rdata;
        end
        if (CW'(j_r) == cm1) begin
          state_nxt = S_TAIL;
        end else begin
          j_nxt     = j_r + AW'(1);
          mem_raddr = j_r + AW'(1);
        end
      end
      S_TAIL: begin
        // drop the largest element of this pass into the last slot
        mem_we    = 1'b1;
        mem_waddr = cm1[AW-1:0];
        mem_wdata = carry_r;
        if (swp_r) begin
          state_nxt = S_PRIME;
        end else begin
          k_nxt     = '0;
          state_nxt = S_EREAD;
        end
      end
      S_EREAD: begin
        mem_raddr = k_r;
        state_nxt = S_EOUT;
      end
      S_EOUT: begin
        // hold the read address until the output register frees up
        mem_raddr = k_r;
        if (out_free) begin
          emit.valid             = 1'b1;
          emit.beat.sorted_value = mem_rdata;
          emit.beat.last_result  = emit_last;
          emit.beat.overflowed   = ovf_r;
          if (emit_last) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_r + AW'(1);
            mem_raddr = k_r + AW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    j_r     <= j_nxt;
    k_r     <= k_nxt;
    swp_r   <= swp_nxt;
    carry_r <= carry_nxt;
  end

  `BSE_ASSERT_SAME(a_cnt_bound, 1'b1, (cnt_r <= CW'(DEPTH)), "element count above depth")
  `BSE_ASSERT_SAME(a_sort_waddr, (mem_we && (state_r != S_LOAD)), (CW'(mem_waddr) < cnt_r), "sort write outside the stored range")
  `BSE_ASSERT_SAME(a_step_idx, (state_r == S_STEP), ((j_r != '0) && (CW'(j_r) < cnt_r)), "pass index outside the stored range")
  `BSE_ASSERT_NEXT(a_run_clear, (emit.valid && emit.beat.last_result), ((cnt_r == '0) && !ovf_r && (state_r == S_LOAD)), "run state not cleared after the final result")

endmodule

// File: bench/bubble_sort_engine_checker.sv
// ----------------------------------------------------------------------------
// bubble_sort_engine_checker
// Watches both channels of the sort engine. It collects each accepted element,
// sorts a copy of the set when the last mark arrives, and compares every
// result beat with the oldest expected one. It reports mismatches and how
// many results are still outstanding.
// ----------------------------------------------------------------------------
module bubble_sort_engine_checker #(
  parameter int DEPTH = bse_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  bse_pkg::in_beat_t  in_beat,
  input  logic               out_valid,
  input  logic               out_stall,
  input  bse_pkg::out_beat_t out_beat,
  output int                 mismatch_count,
  output int                 results_pending
);

  logic signed [bse_pkg::DATA_W-1:0] held_elements [DEPTH];
  int                                held_count;
  logic                              dropped_any;
  bse_pkg::out_beat_t                sorted_results_q [$];
  int                                fail_total;

  // Sort the held set and queue one result beat per element
  task automatic queue_sorted_set();
    logic signed [bse_pkg::DATA_W-1:0] run [DEPTH];
    logic signed [bse_pkg::DATA_W-1:0] swap_tmp;
    bse_pkg::out_beat_t                beat;
    bit                                swapped;
    for (int k = 0; k < held_count; k++) run[k] = held_elements[k];
    // Repeat passes until one makes no swap; equal neighbors never move
    do begin
      swapped = 1'b0;
      for (int j = 0; j + 1 < held_count; j++) begin
        if (run[j] > run[j+1]) begin
          swap_tmp = run[j];
          run[j]   = run[j+1];
          run[j+1] = swap_tmp;
          swapped  = 1'b1;
        end
      end
    end while (swapped);
    for (int k = 0; k < held_count; k++) begin
      beat.sorted_value = run[k];
      beat.last_result  = (k == held_count - 1);
      beat.overflowed   = dropped_any;
      sorted_results_q.push_back(beat);
    end
  endtask

  task automatic log_mismatch(input bse_pkg::out_beat_t want, input bit unexpected);
    if (fail_total < 10) begin
      if (unexpected) begin
        $display("mismatch: unexpected result value=%0d last=%0b ovf=%0b",
                 out_beat.sorted_value, out_beat.last_result, out_beat.overflowed);
      end else begin
        $display("mismatch: expected value=%0d last=%0b ovf=%0b, got value=%0d last=%0b ovf=%0b",
                 want.sorted_value, want.last_result, want.overflowed,
                 out_beat.sorted_value, out_beat.last_result, out_beat.overflowed);
      end
    end
    fail_total++;
  endtask

  always @(posedge clk) begin
    bse_pkg::out_beat_t want;
    if (!rst_n) begin
      held_count  = 0;
      dropped_any = 1'b0;
      fail_total  = 0;
      sorted_results_q.delete();
    end else begin
      // Compare each accepted result beat against the oldest expectation
      if (out_valid && !out_stall) begin
        if (sorted_results_q.size() == 0) begin
          want = '0;
          log_mismatch(want, 1'b1);
        end else begin
          want = sorted_results_q.pop_front();
          if (out_beat.sorted_value !== want.sorted_value ||
              out_beat.last_result  !== want.last_result  ||
              out_beat.overflowed   !== want.overflowed) begin
            log_mismatch(want, 1'b0);
          end
        end
      end
      // Store the element, or drop it and flag overflow when the buffer is full
      if (in_valid && !in_stall) begin
        if (held_count < DEPTH) begin
          held_elements[held_count] = in_beat.value;
          held_count++;
        end else begin
          dropped_any = 1'b1;
        end
        if (in_beat.last_item) begin
          queue_sorted_set();
          held_count  = 0;
          dropped_any = 1'b0;
        end
      end
    end
    mismatch_count  <= fail_total;
    results_pending <= sorted_results_q.size();
  end

endmodule

// File: bench/bubble_sort_engine_top_tb.sv
// ----------------------------------------------------------------------------
// bubble_sort_engine_top_tb
// Feeds the sort engine a few hand-picked sets (extremes, duplicates, sorted
// and reversed order) and then random sets of mostly small sizes, with a few
// full and overflowing ones. Both channels idle at random except during a
// calm stretch. A checker beside the engine predicts and compares results.
// ----------------------------------------------------------------------------
module bubble_sort_engine_top_tb;

  localparam int DEPTH           = bse_pkg::DEPTH_DEF;
  localparam int RANDOM_ELEMENTS = 450;
  localparam int SETTLE_CYCLES   = 50;
  // Full sets take the longest to sort; this limit leaves a wide margin
  localparam int CYCLE_LIMIT     = 600_000;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  bse_pkg::in_beat_t  in_beat   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  bse_pkg::out_beat_t out_beat;
  int                 mismatch_count;
  int                 results_pending;
  int                 cycle_count = 0;
  bit                 calm        = 1'b0;
  int                 elements_sent;
  int                 set_index;
  int                 set_length;

  bubble_sort_engine_top #(.DEPTH(DEPTH)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  bubble_sort_engine_checker #(.DEPTH(DEPTH)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_beat         (in_beat),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_beat        (out_beat),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stall the result channel now and then, except in the calm stretch
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 8);
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one element and hold it until the engine takes the beat
  task automatic push_element(input logic signed [31:0] element, input logic last_mark);
    bse_pkg::in_beat_t beat;
    beat.value     = element;
    beat.last_item = last_mark;
    while (!calm && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= beat;
    do @(posedge clk); while (in_stall);
  endtask

  // Mostly full-range values, some small ones for duplicates, a few extremes
  function automatic logic signed [31:0] pick_element();
    int roll;
    roll = $urandom_range(99);
    if (roll < 65) return $urandom;
    if (roll < 90) return $signed($urandom_range(16)) - 8;
    case ($urandom_range(3))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return 32'sh0000_0000;
      default: return -32'sd1;
    endcase
  endfunction

  // Favor short sets; a few fill the buffer or spill past it
  function automatic int pick_set_length();
    int roll;
    roll = $urandom_range(99);
    if (roll < 78) return $urandom_range(12, 1);
    if (roll < 92) return $urandom_range(40, 13);
    if (roll < 96) return DEPTH;
    return DEPTH + $urandom_range(8, 1);
  endfunction

  task automatic send_random_set(input int length);
    for (int k = 0; k < length; k++) push_element(pick_element(), k == length - 1);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-element sets at both extremes
    push_element(32'sh7fff_ffff, 1'b1);
    push_element(32'sh8000_0000, 1'b1);
    // Equal pair: must come out unchanged
    push_element(32'sd5, 1'b0);
    push_element(32'sd5, 1'b1);
    // Extremes mixed with zero and ones, duplicated extremes
    push_element(32'sd0, 1'b0);
    push_element(-32'sd1, 1'b0);
    push_element(32'sd1, 1'b0);
    push_element(32'sh7fff_ffff, 1'b0);
    push_element(32'sh8000_0000, 1'b0);
    push_element(32'sh8000_0000, 1'b0);
    push_element(32'sh7fff_ffff, 1'b1);
    // Already ascending: early exit after one pass
    push_element(-32'sd3, 1'b0);
    push_element(-32'sd2, 1'b0);
    push_element(-32'sd1, 1'b0);
    push_element(32'sd0, 1'b0);
    push_element(32'sd1, 1'b0);
    push_element(32'sd2, 1'b1);
    // Descending: worst case number of passes
    push_element(32'sd3, 1'b0);
    push_element(32'sd2, 1'b0);
    push_element(32'sd1, 1'b0);
    push_element(32'sd0, 1'b0);
    push_element(-32'sd1, 1'b0);
    push_element(-32'sd2, 1'b1);

    // Random sets; start with an overflowing set and a full one
    elements_sent = 0;
    set_index     = 0;
    while (elements_sent < RANDOM_ELEMENTS) begin
      if (set_index == 0) begin
        set_length = DEPTH + 2;
      end else if (set_index == 1) begin
        set_length = DEPTH;
      end else begin
        set_length = pick_set_length();
      end
      calm <= (set_index >= 20 && set_index < 32);
      send_random_set(set_length);
      elements_sent += set_length;
      set_index++;
    end

    // Drain: wait for every expected result, then watch for strays
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
